// ===== hdl/ids_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ids_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] K_READ       = 3'd4;
    localparam logic [KIND_W-1:0] K_WRITE      = 3'd5;
    localparam logic [KIND_W-1:0] K_REMOVE     = 3'd6;
    localparam logic [KIND_W-1:0] K_NOP        = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [WORD_W-1:0]   data;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/ids_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ids_mem
    import ids_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [DATA_WIDTH-1:0]        o_rd_data,
    input  wire                          i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire  [DATA_WIDTH-1:0]        i_wr_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/ids_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ids_ctrl
    import ids_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [KIND_W-1:0]            i_kind,
    input  wire  [POS_W-1:0]             i_position,
    input  wire  [WORD_W-1:0]            i_data_in,
    input  wire                          i_out_free,
    output logic                         o_res_valid,
    output t_result                      o_res,
    output logic                         o_mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]     o_mem_rd_addr,
    input  wire  [DATA_WIDTH-1:0]        i_mem_rd_data,
    output logic                         o_mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]     o_mem_wr_addr,
    output logic [DATA_WIDTH-1:0]        o_mem_wr_data
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int WW  = (CW > POS_W) ? CW : POS_W;
    localparam int XDW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
    localparam int XCW = (CW > COUNT_W) ? CW : COUNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SH_RD = 2'd2;
    localparam logic [1:0] S_SH_WR = 2'd3;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        f_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] p);
        f_dec = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [PW-1:0] f_slot(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PW + 1)'(DEPTH)) begin
            sum = sum - (PW + 1)'(DEPTH);
        end
        f_slot = sum[PW-1:0];
    endfunction

    logic [1:0]            r_state, n_state;
    logic [PW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [PW-1:0]         r_addr, n_addr;
    logic [CW-1:0]         r_idx, n_idx;
    logic [DATA_WIDTH-1:0] r_word, n_word;

    logic [WW-1:0]         pos_x;
    logic [WW-1:0]         cnt_x;
    logic [XDW-1:0]        word_x;
    logic [XDW-1:0]        rd_x;
    logic [XCW-1:0]        cnt_out;
    logic [CW-1:0]         cnt_dec;

    always_comb begin
        pos_x   = WW'(i_position);
        cnt_x   = WW'(r_count);
        word_x  = XDW'(i_data_in);
        rd_x    = XDW'(i_mem_rd_data);
        cnt_dec = r_count - 1'b1;

        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_kind   = r_kind;
        n_status = r_status;
        n_addr   = r_addr;
        n_idx    = r_idx;
        n_word   = r_word;

        o_in_ready    = 1'b0;
        o_res_valid   = 1'b0;
        o_res         = '0;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_addr;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_addr;
        o_mem_wr_data = r_word;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind   = i_kind;
                    n_word   = word_x[DATA_WIDTH-1:0];
                    n_idx    = pos_x[CW-1:0];
                    n_status = ST_OK;
                    case (i_kind)
                        K_PUSH_FRONT: begin
                            n_addr = f_dec(r_front);
                            if (r_count == CW'(DEPTH)) n_status = ST_FULL;
                        end
                        K_PUSH_BACK: begin
                            n_addr = f_slot(r_front, r_count[PW-1:0]);
                            if (r_count == CW'(DEPTH)) n_status = ST_FULL;
                        end
                        K_POP_FRONT: begin
                            n_addr = r_front;
                            if (r_count == '0) n_status = ST_EMPTY;
                        end
                        K_POP_BACK: begin
                            n_addr = f_slot(r_front, cnt_dec[PW-1:0]);
                            if (r_count == '0) n_status = ST_EMPTY;
                        end
                        K_READ, K_WRITE, K_REMOVE: begin
                            n_addr = f_slot(r_front, pos_x[PW-1:0]);
                            if (pos_x >= cnt_x) n_status = ST_RANGE;
                        end
                        default: begin
                            n_addr = r_front;
                        end
                    endcase
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = n_addr;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_out_free) begin
                    o_res_valid   = 1'b1;
                    o_res.status  = r_status;
                    n_state       = S_IDLE;
                    if (r_status == ST_OK) begin
                        case (r_kind)
                            K_PUSH_FRONT: begin
                                o_mem_wr_en = 1'b1;
                                n_front     = r_addr;
                                n_count     = r_count + 1'b1;
                            end
                            K_PUSH_BACK: begin
                                o_mem_wr_en = 1'b1;
                                n_count     = r_count + 1'b1;
                            end
                            K_POP_FRONT: begin
                                o_res.data = rd_x[WORD_W-1:0];
                                n_front    = f_inc(r_front);
                                n_count    = cnt_dec;
                            end
                            K_POP_BACK: begin
                                o_res.data = rd_x[WORD_W-1:0];
                                n_count    = cnt_dec;
                            end
                            K_READ: begin
                                o_res.data = rd_x[WORD_W-1:0];
                            end
                            K_WRITE: begin
                                o_mem_wr_en = 1'b1;
                            end
                            K_REMOVE: begin
                                o_res.data = rd_x[WORD_W-1:0];
                                n_count    = cnt_dec;
                                if (r_idx < cnt_dec) n_state = S_SH_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_SH_RD: begin
                o_mem_rd_en   = 1'b1;
                o_mem_rd_addr = f_inc(r_addr);
                n_state       = S_SH_WR;
            end
            S_SH_WR: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_data = i_mem_rd_data;
                n_addr        = f_inc(r_addr);
                n_idx         = r_idx + 1'b1;
                n_state       = (n_idx < r_count) ? S_SH_RD : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        cnt_out     = XCW'(n_count);
        o_res.count = cnt_out[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_word   <= n_word;
    end

endmodule

`default_nettype wire

// ===== hdl/indexed_deque_store.sv =====
// A result goes through the execute state, which waits while the output register
// holds an unaccepted result, into the output register. No new operation is taken
// until the last is through; the entry memory read is registered (address in the
// accept cycle, read-modify-write in S_EXEC). Remove at shifts each entry behind
// the removed one before the next input is taken, each with a memory read and write.
// Reset (i_rst_n, synchronous, active low) empties the list; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module indexed_deque_store
    import ids_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [S_TDATA_W-1:0]   s_axis_tdata,   // position[5:0], data_in[37:6]
    input  wire  [KIND_W-1:0]      s_axis_tuser,   // kind[2:0]
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // data_out[31:0], entry_count[38:32]
    output logic [STATUS_W-1:0]    m_axis_tuser    // status[1:0]
);

    localparam int PW = $clog2(DEPTH);

    logic                  out_free;
    logic                  res_valid;
    t_result               res;
    logic                  mem_rd_en;
    logic [PW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;
    logic                  mem_wr_en;
    logic [PW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;

    logic                  r_out_valid;
    t_result               r_out;

    assign out_free = !r_out_valid || m_axis_tready;

    ids_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_position    (s_axis_tdata[POS_W-1:0]),
        .i_data_in     (s_axis_tdata[POS_W+WORD_W-1:POS_W]),
        .i_out_free    (out_free),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data)
    );

    ids_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.count, r_out.data};
    assign m_axis_tuser  = r_out.status;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || m_axis_tready))
        else $error("result produced while output register still held");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !s_axis_tready)
        else $error("input taken while a result is being produced");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.status == ST_EMPTY) |-> (res.data == '0 && res.count == '0))
        else $error("empty status with nonzero data or count");

    a_load_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> m_axis_tvalid)
        else $error("result did not reach the output register");

endmodule

`default_nettype wire
